>>> src/i2cm_pkg.sv
package i2cm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
	localparam logic [1:0] REG_HALF_PERIOD_TICKS = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT       = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// reset values of the configuration registers
	localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'd35;
	localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd100;
	localparam logic [15:0] ACK_TIMEOUT_RST       = 16'd300;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// completion status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NACK    = 2'd1;
	localparam logic [1:0] STAT_BAD_LEN = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_A   = 4'd1,
		PH_START_B   = 4'd2,
		PH_TX_LOW    = 4'd3,
		PH_TX_HIGH   = 4'd4,
		PH_ACK_LOW   = 4'd5,
		PH_ACK_HIGH  = 4'd6,
		PH_ACK_WAIT  = 4'd7,
		PH_RX_HIGH   = 4'd8,
		PH_RX_LOW    = 4'd9,
		PH_MACK_LOW  = 4'd10,
		PH_MACK_HIGH = 4'd11,
		PH_STOP_A    = 4'd12,
		PH_STOP_B    = 4'd13,
		PH_STOP_C    = 4'd14
	} phase_t;

	typedef struct packed {
		logic       mode;
		logic       start_request;
		logic [7:0] command_byte;
		logic [7:0] read_count;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       last_byte;
		logic       done_res;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [15:0] half_period_ticks;
		logic [15:0] ack_timeout;
	} cfg_t;

endpackage

>>> src/i2cm_if.sv
interface i2cm_req_if;
	import i2cm_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
	import i2cm_pkg::*;

	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/i2cm_core.sv
module i2cm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  i2cm_pkg::req_t req,
	input  i2cm_pkg::cfg_t cfg,
	output i2cm_pkg::res_t res
);
	import i2cm_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0]  bit_idx_q, bit_idx_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  left_q, left_d;
	logic [15:0] ackw_q, ackw_d;
	logic        is_read_q, is_read_d;
	logic [7:0]  cmd_q, cmd_d;
	logic        failed_q, failed_d;

	logic [15:0] hp;
	logic [16:0] tick_inc;
	logic        hp_over;
	logic [15:0] tick_adv;
	logic [16:0] ackw_inc;
	logic [3:0]  bit_idx_inc;
	logic [7:0]  left_dec;
	logic        mack;

	// half period of zero behaves as one
	assign hp          = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
	assign tick_inc    = {1'b0, tick_q} + 17'd1;
	assign hp_over     = tick_inc >= {1'b0, hp};
	assign tick_adv    = hp_over ? 16'd0 : tick_inc[15:0];
	assign ackw_inc    = {1'b0, ackw_q} + 17'd1;
	assign bit_idx_inc = bit_idx_q + 4'd1;
	assign left_dec    = (left_q != '0) ? left_q - 8'd1 : 8'd0;
	assign mack        = left_q <= 8'd1;

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		left_d    = left_q;
		ackw_d    = ackw_q;
		is_read_d = is_read_q;
		cmd_d     = cmd_q;
		failed_d  = failed_q;

		res            = '0;
		res.scl_out    = 1'b1;
		res.sda_out    = 1'b1;
		res.busy_res   = 1'b1;

		// bus levels come from the phase this tick is spent in
		case (phase_q)
			PH_START_B: res.sda_out = 1'b0;
			PH_TX_LOW: begin
				res.scl_out = 1'b0;
				res.sda_out = shift_q[7];
			end
			PH_TX_HIGH: res.sda_out = shift_q[7];
			PH_ACK_LOW, PH_RX_LOW: res.scl_out = 1'b0;
			PH_MACK_LOW: begin
				res.scl_out = 1'b0;
				res.sda_out = mack;
			end
			PH_MACK_HIGH: res.sda_out = mack;
			PH_STOP_A: begin
				res.scl_out = 1'b0;
				res.sda_out = 1'b0;
			end
			PH_STOP_B: res.sda_out = 1'b0;
			PH_IDLE: res.busy_res = 1'b0;
			default: ;
		endcase

		case (phase_q)
			PH_IDLE: begin
				if (req.start_request) begin
					if (req.mode && req.read_count == '0) begin
						res.done_res = 1'b1;
						res.status   = STAT_BAD_LEN;
					end else begin
						shift_d   = {cfg.device_address, req.mode};
						bit_idx_d = '0;
						tick_d    = '0;
						ackw_d    = '0;
						is_read_d = req.mode;
						left_d    = req.mode ? req.read_count : 8'd1;
						cmd_d     = req.command_byte;
						failed_d  = 1'b0;
						phase_d   = PH_START_A;
					end
				end
			end
			PH_START_A: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_START_B;
			end
			PH_START_B: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				tick_d = tick_adv;
				if (hp_over) begin
					shift_d   = {shift_q[6:0], 1'b0};
					bit_idx_d = bit_idx_inc;
					phase_d   = (bit_idx_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
				end
			end
			PH_ACK_LOW: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				tick_d = tick_adv;
				if (hp_over) begin
					ackw_d  = '0;
					phase_d = PH_ACK_WAIT;
				end
			end
			PH_ACK_WAIT: begin
				if (!req.sda_in) begin
					tick_d    = '0;
					bit_idx_d = '0;
					ackw_d    = '0;
					if (is_read_q) begin
						shift_d = '0;
						phase_d = PH_RX_HIGH;
					end else if (left_q != '0) begin
						// address acked: send the held command byte
						left_d  = '0;
						shift_d = cmd_q;
						phase_d = PH_TX_LOW;
					end else begin
						phase_d = PH_STOP_A;
					end
				end else if (ackw_inc > {1'b0, cfg.ack_timeout}) begin
					failed_d = 1'b1;
					tick_d   = '0;
					ackw_d   = '0;
					phase_d  = PH_STOP_A;
				end else begin
					ackw_d = ackw_inc[15:0];
				end
			end
			PH_RX_HIGH: begin
				tick_d = tick_adv;
				if (hp_over) begin
					shift_d = {shift_q[6:0], req.sda_in};
					phase_d = PH_RX_LOW;
				end
			end
			PH_RX_LOW: begin
				tick_d = tick_adv;
				if (hp_over) begin
					bit_idx_d = bit_idx_inc;
					if (bit_idx_inc >= BITS_PER_BYTE) begin
						res.read_byte  = shift_q;
						res.byte_valid = 1'b1;
						res.last_byte  = mack;
						phase_d        = PH_MACK_LOW;
					end else begin
						phase_d = PH_RX_HIGH;
					end
				end
			end
			PH_MACK_LOW: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_MACK_HIGH;
			end
			PH_MACK_HIGH: begin
				tick_d = tick_adv;
				if (hp_over) begin
					left_d    = left_dec;
					bit_idx_d = '0;
					shift_d   = '0;
					phase_d   = (left_dec == '0) ? PH_STOP_A : PH_RX_HIGH;
				end
			end
			PH_STOP_A: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_STOP_B;
			end
			PH_STOP_B: begin
				tick_d = tick_adv;
				if (hp_over) phase_d = PH_STOP_C;
			end
			PH_STOP_C: begin
				tick_d = tick_adv;
				if (hp_over) begin
					res.done_res = 1'b1;
					res.status   = failed_q ? STAT_NACK : STAT_OK;
					phase_d      = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
			left_q    <= '0;
			ackw_q    <= '0;
			is_read_q <= 1'b0;
			cmd_q     <= '0;
			failed_q  <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			left_q    <= left_d;
			ackw_q    <= ackw_d;
			is_read_q <= is_read_d;
			cmd_q     <= cmd_d;
			failed_q  <= failed_d;
		end
	end

endmodule

>>> src/i2c_master_bit_engine.sv
// I2C master bit engine, 7-bit addressing. Every transfer on req is one bus
// tick: it carries the sampled SDA level plus a request (write one command
// byte, or read read_count bytes) that is only looked at while idle. Every
// req transfer yields exactly one rsp transfer with the SCL/SDA drive levels
// for that tick, busy, any received byte with its last flag, and done with
// status (ok, no acknowledge, bad length). One tick is taken per clock while
// rsp is not stalled; the rsp payload is registered and appears in the cycle
// after its req transfer from the output register, and req stays ready while
// that register is empty or being drained, so ticks stream back to back. SCL
// half periods last half_period_ticks ticks (0 acts as 1); ACK waits give up
// once more than ack_timeout high samples are seen. Configuration is written
// through cfg_we, cfg_index and cfg_data; index 3 is ignored.
module i2c_master_bit_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	i2cm_req_if.sink                             req,
	i2cm_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import i2cm_pkg::*;

	cfg_t cfg_q;
	res_t core_res;
	res_t rsp_data_q;
	logic rsp_valid_q;
	logic adv;

	// config registers, effective from the next tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= DEVICE_ADDRESS_RST;
			cfg_q.half_period_ticks <= HALF_PERIOD_TICKS_RST;
			cfg_q.ack_timeout       <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data[6:0];
				REG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data;
				REG_ACK_TIMEOUT:       cfg_q.ack_timeout       <= cfg_data;
				default: ;
			endcase
		end
	end

	// take a tick whenever the output slot is free or emptying this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign adv       = req.valid && req.ready;

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req.payload),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data_q <= core_res;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule

>>> src/i2cm_checker.sv
module i2cm_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  i2cm_pkg::res_t rsp_payload
);
	import i2cm_pkg::*;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("rsp changed while stalled");

	// status only reported with done
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != STAT_OK |-> rsp_payload.done_res)
		else $error("status without done");

	// a byte never completes on the done tick
	a_byte_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_payload.byte_valid && rsp_payload.done_res))
		else $error("byte and done together");

	a_last_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.last_byte |-> rsp_payload.byte_valid)
		else $error("last flag without byte");

	// idle bus is released
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_payload.busy_res |-> rsp_payload.scl_out && rsp_payload.sda_out)
		else $error("bus driven while idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
